>>> design/sktl_pkg.sv
package sktl_pkg;

  localparam int KEY_BITS = 24;
  localparam int IN_REF_BITS = 20;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int REF_BITS_DEF = 20;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Request traveling down the cell chain.
  // Insert: key/ref hold the entry still to be placed.
  // Lookup: key is the search key, ref the reference found so far.
  typedef struct packed {
    logic                   vld;
    op_t                    op;
    logic                   carry;
    logic                   shifting;
    logic                   resolved;
    status_t                status;
    logic [KEY_BITS-1:0]    key;
    logic [IN_REF_BITS-1:0] ref_val;
  } token_t;

endpackage

>>> design/sorted_key_table_lookup_core.sv
// Sorted key table with lookup, built as a chain of TABLE_DEPTH cells that each
// hold one entry in ascending key order (equal keys kept in insertion order).
// Every request walks the chain one cell per cycle while the chain advances:
// an insert drops its entry into place and shifts the larger entries one cell
// on, a lookup picks up the reference of the first entry with an equal key.
// Results leave the last cell in request order, and a new request may enter
// every cycle; the whole chain holds while a result waits on m_axis_tready.
// An insert into a full table answers with the full status.
module sorted_key_table_lookup_core #(
  parameter int TABLE_DEPTH = sktl_pkg::TABLE_DEPTH_DEF,
  parameter int REF_BITS = sktl_pkg::REF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // catalog_number[23:0], star_ref[43:24], zero
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status[1:0], found_ref[21:2], zero
);

  localparam int STORE_BITS = (REF_BITS < sktl_pkg::IN_REF_BITS) ?
                              REF_BITS : sktl_pkg::IN_REF_BITS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic             adv;
  logic             accept;
  logic             full;

  sktl_pkg::token_t tok [TABLE_DEPTH+1];
  logic [CNT_W-1:0] rem [TABLE_DEPTH+1];

  logic [sktl_pkg::IN_REF_BITS-1:0] ref_mask;
  sktl_pkg::token_t                 head;
  sktl_pkg::token_t                 last;

  assign adv = !tok[TABLE_DEPTH].vld || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept = s_axis_tvalid && adv;
  assign full = (count == CNT_W'(TABLE_DEPTH));
  assign ref_mask = sktl_pkg::IN_REF_BITS'((21'(1) << STORE_BITS) - 21'(1));

  always_comb begin
    head.vld = accept;
    head.op = sktl_pkg::op_t'(s_axis_tuser);
    head.shifting = 1'b0;
    head.resolved = 1'b0;
    head.key = s_axis_tdata[23:0];
    if (s_axis_tuser == sktl_pkg::OP_LOOKUP) begin
      head.carry = 1'b0;
      head.status = sktl_pkg::ST_NOT_FOUND;
      head.ref_val = '0;
    end else if (full) begin
      head.carry = 1'b0;
      head.status = sktl_pkg::ST_FULL;
      head.ref_val = '0;
    end else begin
      head.carry = 1'b1;
      head.status = sktl_pkg::ST_INSERTED;
      head.ref_val = s_axis_tdata[43:24] & ref_mask;
    end
  end

  assign tok[0] = head;
  assign rem[0] = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && s_axis_tuser == sktl_pkg::OP_INSERT && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sktl_cell #(
      .STORE_BITS(STORE_BITS),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .tok_in(tok[i]),
      .rem_in(rem[i]),
      .tok_out(tok[i+1]),
      .rem_out(rem[i+1])
    );
  end

  assign last = tok[TABLE_DEPTH];
  assign m_axis_tvalid = last.vld;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[1:0] = last.status;
    if (last.status == sktl_pkg::ST_FOUND) begin
      m_axis_tdata[21:2] = last.ref_val;
    end
  end

endmodule

>>> design/sktl_cell.sv
module sktl_cell #(
  parameter int STORE_BITS = sktl_pkg::REF_BITS_DEF,
  parameter int CNT_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  sktl_pkg::token_t tok_in,
  input  logic [CNT_W-1:0] rem_in,
  output sktl_pkg::token_t tok_out,
  output logic [CNT_W-1:0] rem_out
);

  logic [sktl_pkg::KEY_BITS-1:0] key;
  logic [STORE_BITS-1:0]         ref_val;

  sktl_pkg::token_t tok_next;
  logic [CNT_W-1:0] rem_next;
  logic             occupied;
  logic             take;

  assign occupied = (rem_in != '0);

  always_comb begin
    tok_next = tok_in;
    rem_next = occupied ? rem_in - CNT_W'(1) : '0;
    take = 1'b0;
    if (tok_in.vld && tok_in.op == sktl_pkg::OP_INSERT && tok_in.carry) begin
      if (tok_in.shifting || !occupied || key > tok_in.key) begin
        take = 1'b1;
        if (occupied) begin
          tok_next.key = key;
          tok_next.ref_val = sktl_pkg::IN_REF_BITS'(ref_val);
          tok_next.shifting = 1'b1;
        end else begin
          tok_next.carry = 1'b0;
        end
      end
    end
    if (tok_in.vld && tok_in.op == sktl_pkg::OP_LOOKUP && !tok_in.resolved) begin
      if (occupied && key == tok_in.key) begin
        tok_next.resolved = 1'b1;
        tok_next.status = sktl_pkg::ST_FOUND;
        tok_next.ref_val = sktl_pkg::IN_REF_BITS'(ref_val);
      end else if (!occupied || key > tok_in.key) begin
        tok_next.resolved = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      key <= tok_in.key;
      ref_val <= tok_in.ref_val[STORE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
      rem_out <= rem_next;
    end
  end

endmodule

>>> tb/tb_sorted_key_table_lookup_core.sv
module tb_sorted_key_table_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = sktl_pkg::TABLE_DEPTH_DEF;
  localparam int KB = sktl_pkg::KEY_BITS;
  localparam int RB = sktl_pkg::IN_REF_BITS;
  localparam int DRAIN_CYCLES = DEPTH + 64;
  localparam int STALL_LIMIT = 50000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_REQUESTS = 1300;
  localparam logic [KB-1:0] KEY_MAX = '1;
  localparam logic [RB-1:0] REF_MAX = '1;

  typedef struct packed {
    sktl_pkg::status_t status;
    logic [RB-1:0]     found_ref;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // catalog_number[23:0], star_ref[43:24], zero
  logic        s_axis_tuser = 1'b0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // status[1:0], found_ref[21:2], zero

  always #2 clk = ~clk;

  sorted_key_table_lookup_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  logic [KB-1:0] table_keys[DEPTH];
  logic [RB-1:0] table_refs[DEPTH];
  int            table_count = 0;
  answer_t       expected_answers[$];
  int            failure_count = 0;
  int            burst_left = 0;
  int            idle_cycles = 0;
  int            stall_pct = 0;
  int            stall_phase_left = 0;

  function automatic logic [KB-1:0] rand_key();
    return KB'($urandom_range(0, KEY_MAX));
  endfunction

  function automatic logic [RB-1:0] rand_ref();
    return RB'($urandom_range(0, REF_MAX));
  endfunction

  // First slot whose key is above the given one (skip_equal) or not below it.
  function automatic int key_position(logic [KB-1:0] key, bit skip_equal);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = table_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (skip_equal ? (table_keys[mid] <= key) : (table_keys[mid] < key)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic answer_t predict_answer(sktl_pkg::op_t op, logic [KB-1:0] key,
                                             logic [RB-1:0] sref);
    answer_t ans;
    int      pos;
    ans.found_ref = '0;
    if (op == sktl_pkg::OP_INSERT) begin
      if (table_count >= DEPTH) begin
        ans.status = sktl_pkg::ST_FULL;
      end else begin
        pos = key_position(key, 1'b1);
        for (int i = table_count; i > pos; i--) begin
          table_keys[i] = table_keys[i-1];
          table_refs[i] = table_refs[i-1];
        end
        table_keys[pos] = key;
        table_refs[pos] = sref;
        table_count++;
        ans.status = sktl_pkg::ST_INSERTED;
      end
    end else begin
      pos = key_position(key, 1'b0);
      if (pos < table_count && table_keys[pos] == key) begin
        ans.status = sktl_pkg::ST_FOUND;
        ans.found_ref = table_refs[pos];
      end else begin
        ans.status = sktl_pkg::ST_NOT_FOUND;
      end
    end
    return ans;
  endfunction

  task automatic send_request(sktl_pkg::op_t op, logic [KB-1:0] key,
                              logic [RB-1:0] sref);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, sref, key};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    expected_answers.push_back(predict_answer(op, key, sref));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(0, 30);
    end
  endtask

  function automatic logic [KB-1:0] pick_key();
    logic [KB-1:0] key;
    int            sel;
    sel = $urandom_range(0, 9);
    key = rand_key();
    if (table_count > 0 && sel >= 4 && sel <= 6) begin
      key = table_keys[$urandom_range(0, table_count - 1)];
    end else if (table_count > 0 && sel == 7) begin
      key = table_keys[$urandom_range(0, table_count - 1)];
      key = $urandom_range(0, 1) ? key + 1'b1 : key - 1'b1;
    end else if (sel == 8) begin
      key = KB'($urandom_range(0, 15));
    end else if (sel == 9) begin
      key = $urandom_range(0, 1) ? KEY_MAX : '0;
    end
    return key;
  endfunction

  task automatic test_empty_table();
    send_request(sktl_pkg::OP_LOOKUP, '0, '0);
    send_request(sktl_pkg::OP_LOOKUP, KEY_MAX, REF_MAX);
    send_request(sktl_pkg::OP_LOOKUP, rand_key(), rand_ref());
  endtask

  task automatic test_key_extremes();
    send_request(sktl_pkg::OP_INSERT, '0, '0);
    send_request(sktl_pkg::OP_INSERT, KEY_MAX, REF_MAX);
    send_request(sktl_pkg::OP_INSERT, 24'h800000, 20'hAAAAA);
    send_request(sktl_pkg::OP_LOOKUP, '0, REF_MAX);
    send_request(sktl_pkg::OP_LOOKUP, KEY_MAX, '0);
    send_request(sktl_pkg::OP_LOOKUP, 24'h800000, 20'h55555);
    send_request(sktl_pkg::OP_LOOKUP, 24'h000001, '0);
    send_request(sktl_pkg::OP_LOOKUP, KEY_MAX - 1'b1, '0);
  endtask

  task automatic test_duplicate_keys();
    send_request(sktl_pkg::OP_INSERT, 24'h123456, 20'h00001);
    send_request(sktl_pkg::OP_INSERT, 24'h123456, 20'h00002);
    send_request(sktl_pkg::OP_INSERT, 24'h123456, 20'h00003);
    send_request(sktl_pkg::OP_LOOKUP, 24'h123456, '0);
    send_request(sktl_pkg::OP_INSERT, 24'h000005, 20'h12345);
    send_request(sktl_pkg::OP_INSERT, '0, 20'h0F0F0);
    send_request(sktl_pkg::OP_LOOKUP, 24'h123456, REF_MAX);
    send_request(sktl_pkg::OP_LOOKUP, '0, '0);
  endtask

  task automatic test_random_mix();
    sktl_pkg::op_t op;
    repeat (RANDOM_REQUESTS) begin
      op = ($urandom_range(0, 99) < 60) ? sktl_pkg::OP_INSERT : sktl_pkg::OP_LOOKUP;
      send_request(op, pick_key(), rand_ref());
    end
  endtask

  task automatic test_fill_to_full();
    while (table_count < DEPTH) begin
      send_request(sktl_pkg::OP_INSERT, pick_key(), rand_ref());
    end
    send_request(sktl_pkg::OP_INSERT, 24'h5A5A5A, 20'hA5A5A);
    send_request(sktl_pkg::OP_INSERT, KEY_MAX, REF_MAX);
    send_request(sktl_pkg::OP_INSERT, '0, '0);
    send_request(sktl_pkg::OP_LOOKUP, 24'h5A5A5A, '0);
    send_request(sktl_pkg::OP_LOOKUP, table_keys[0], '0);
    send_request(sktl_pkg::OP_LOOKUP, table_keys[DEPTH-1], '0);
    repeat (20) send_request(sktl_pkg::OP_LOOKUP, pick_key(), rand_ref());
  endtask

  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 95;
      endcase
      stall_phase_left = $urandom_range(16, 300);
    end else begin
      stall_phase_left--;
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_answers.size() == 0) begin
        if (failure_count < REPORT_LIMIT)
          $display("unexpected result: status %0d found_ref %h",
                   m_axis_tdata[1:0], m_axis_tdata[21:2]);
        failure_count++;
      end else begin
        want = expected_answers.pop_front();
        if (m_axis_tdata[1:0] != want.status || m_axis_tdata[21:2] != want.found_ref) begin
          if (failure_count < REPORT_LIMIT)
            $display("mismatch: expected status %0d found_ref %h, got status %0d found_ref %h",
                     want.status, want.found_ref, m_axis_tdata[1:0], m_axis_tdata[21:2]);
          failure_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_sorted_key_table_lookup_core failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_key_extremes();
    test_duplicate_keys();
    test_random_mix();
    test_fill_to_full();
    s_axis_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failure_count == 0 && expected_answers.size() == 0) begin
      $display("tb_sorted_key_table_lookup_core passed");
    end else begin
      $display("tb_sorted_key_table_lookup_core failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sktl_pkg.sv
design/sktl_cell.sv
design/sorted_key_table_lookup_core.sv
tb/tb_sorted_key_table_lookup_core.sv
